// File: src/bbr_pkg.sv
// Package for the clipped RGB box blur: payload types, controller codes, defaults.
`default_nettype none
package bbr_pkg;

  localparam int DEF_RADIUS     = 10;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_W_W-1:0] RST_WIDTH  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] RST_HEIGHT = CFG_H_W'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_done;
  } out_item_t;

  typedef enum logic [3:0] {
    S_READY,
    S_START,
    S_WRITE,
    S_CHECK,
    S_SETUP,
    S_SETUP2,
    S_SETUP3,
    S_SUM,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic cap;
    logic start;
    logic wr;
    logic setup;
    logic setup2;
    logic setup3;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic tick;
    logic emit;
    logic sum_done;
    logic div_done;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

// File: src/bbr_ctrl.sv
// Controller for the box blur: sequences capture, store, window sum, divide and output.
`default_nettype none
module bbr_ctrl
  import bbr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_READY:  if (in_valid) state_next = S_START;
      S_START: begin
        if (!sts.active && sts.tick) state_next = S_READY;
        else state_next = S_WRITE;
      end
      S_WRITE:  state_next = S_CHECK;
      S_CHECK:  state_next = sts.emit ? S_SETUP : S_READY;
      S_SETUP:  state_next = S_SETUP2;
      S_SETUP2: state_next = S_SETUP3;
      S_SETUP3: state_next = S_SUM;
      S_SUM:    if (sts.sum_done) state_next = S_DIV;
      S_DIV:    if (sts.div_done) state_next = S_LOAD;
      S_LOAD:   if (!sts.out_full) state_next = S_READY;
      default:  state_next = S_READY;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_READY: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_START:  cmd.start = !sts.active && !sts.tick;
      S_WRITE:  cmd.wr = 1'b1;
      S_CHECK:  ;
      S_SETUP:  cmd.setup = 1'b1;
      S_SETUP2: cmd.setup2 = 1'b1;
      S_SETUP3: cmd.setup3 = 1'b1;
      S_SUM:    cmd.div_start = sts.sum_done;
      S_DIV:    ;
      S_LOAD:   cmd.load = !sts.out_full;
      default:  ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/bbr_datapath.sv
// Datapath for the box blur: line store, position counters, window summing and divider.
`default_nettype none
module bbr_datapath
  import bbr_pkg::*;
#(
  parameter int RADIUS     = DEF_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              in_data,
  output out_item_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire cmd_t                  cmd,
  output sts_t                       sts
);

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = (2 * RADIUS + 1) * MAX_WIDTH;
  localparam int A_W   = $clog2(DEPTH);
  localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int R_W   = $clog2(2 * RADIUS + 1);
  localparam int WIN   = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int CNT_W = $clog2(WIN + 1);
  localparam int SUM_W = $clog2(WIN * 255 + 1);
  localparam int DC_W  = $clog2(SUM_W + 1);

  logic [CFG_W_W-1:0] img_w;
  logic [CFG_H_W-1:0] img_h;

  logic [W_W-1:0]   frame_w;
  logic [H_W-1:0]   frame_h;
  logic [TOT_W-1:0] total;
  logic [POS_W-1:0] lag;
  logic             active;
  in_item_t         item;

  logic [POS_W-1:0] in_pos;
  logic [A_W-1:0]   wr_addr;
  logic [TOT_W-1:0] out_pos;
  logic [W_W-1:0]   px;
  logic [H_W-1:0]   py;
  logic [A_W-1:0]   addr_p;

  logic [R_W-1:0]   dy, dx, nrows, ncols;
  logic [A_W-1:0]   off;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   row_addr, col_addr;
  logic [R_W-1:0]   row_i, col_i;
  logic             sum_active;
  logic             rd_pend;
  logic [23:0]      rd_data;
  logic [23:0]      line_store [DEPTH];

  logic [2:0][SUM_W-1:0] sums;
  logic [2:0][CNT_W:0]   rem;
  logic [2:0][SUM_W-1:0] quo;
  logic                  div_busy;
  logic [DC_W-1:0]       div_cnt;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= RST_WIDTH;
      img_h <= RST_HEIGHT;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  img_w <= cfg_data[CFG_W_W-1:0];
        REG_HEIGHT: img_h <= cfg_data[CFG_H_W-1:0];
        default:    ;
      endcase
    end
  end

  // clamped geometry for frame start
  logic [W_W-1:0] cw;
  logic [H_W-1:0] ch;
  always_comb begin
    if (img_w == '0) cw = W_W'(1);
    else if (32'(img_w) > 32'(MAX_WIDTH)) cw = W_W'(MAX_WIDTH);
    else cw = W_W'(img_w);
    if (img_h == '0) ch = H_W'(1);
    else if (32'(img_h) > 32'(MAX_HEIGHT)) ch = H_W'(MAX_HEIGHT);
    else ch = H_W'(img_h);
  end

  // window extent around the current output pixel
  logic [R_W-1:0] dy_c, dx_c, down_c, right_c;
  always_comb begin
    dy_c = (32'(py) >= 32'(RADIUS)) ? R_W'(RADIUS) : R_W'(py);
    dx_c = (32'(px) >= 32'(RADIUS)) ? R_W'(RADIUS) : R_W'(px);
    down_c  = (32'(py) + 32'(RADIUS) < 32'(frame_h)) ? R_W'(RADIUS)
                                                     : R_W'(32'(frame_h) - 32'd1 - 32'(py));
    right_c = (32'(px) + 32'(RADIUS) < 32'(frame_w)) ? R_W'(RADIUS)
                                                     : R_W'(32'(frame_w) - 32'd1 - 32'(px));
  end

  // read address walk
  logic           last_issue;
  logic [A_W:0]   row_sum;
  logic [A_W-1:0] row_next;
  logic [A_W-1:0] col_next;
  always_comb begin
    last_issue = (row_i == nrows) && (col_i == ncols);
    row_sum    = {1'b0, row_addr} + (A_W + 1)'(frame_w);
    row_next   = (row_sum >= (A_W + 1)'(DEPTH)) ? A_W'(row_sum - (A_W + 1)'(DEPTH))
                                                : A_W'(row_sum);
    col_next   = (32'(col_addr) == 32'(DEPTH - 1)) ? '0 : col_addr + A_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(in_pos) < 32'(total))) begin
      line_store[wr_addr] <= item.req_type ? 24'd0
                             : {item.in_blue, item.in_green, item.in_red};
    end
    if (sum_active) begin
      rd_data <= line_store[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      sum_active <= 1'b0;
      rd_pend    <= 1'b0;
      div_busy   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pend <= sum_active;
      if (out_valid && out_ready && !cmd.load) out_valid <= 1'b0;

      if (cmd.cap) item <= in_data;

      if (cmd.start) begin
        active  <= 1'b1;
        frame_w <= cw;
        frame_h <= ch;
        total   <= TOT_W'(32'(cw) * 32'(ch));
        lag     <= POS_W'(32'(RADIUS) * 32'(cw) + 32'(RADIUS));
        in_pos  <= '0;
        wr_addr <= '0;
        out_pos <= '0;
        px      <= '0;
        py      <= '0;
        addr_p  <= '0;
      end

      if (cmd.wr) begin
        in_pos  <= in_pos + POS_W'(1);
        wr_addr <= (32'(wr_addr) == 32'(DEPTH - 1)) ? '0 : wr_addr + A_W'(1);
      end

      if (cmd.setup) begin
        dy    <= dy_c;
        dx    <= dx_c;
        nrows <= dy_c + down_c;
        ncols <= dx_c + right_c;
      end

      if (cmd.setup2) begin
        off <= A_W'(32'(dy) * 32'(frame_w) + 32'(dx));
        cnt <= CNT_W'((32'(nrows) + 32'd1) * (32'(ncols) + 32'd1));
      end

      if (cmd.setup3) begin
        row_addr   <= (addr_p >= off) ? addr_p - off : A_W'(32'(addr_p) + 32'(DEPTH) - 32'(off));
        col_addr   <= (addr_p >= off) ? addr_p - off : A_W'(32'(addr_p) + 32'(DEPTH) - 32'(off));
        row_i      <= '0;
        col_i      <= '0;
        sum_active <= 1'b1;
        sums       <= '0;
      end

      if (sum_active) begin
        if (last_issue) begin
          sum_active <= 1'b0;
        end else if (col_i == ncols) begin
          col_i    <= '0;
          row_i    <= row_i + R_W'(1);
          row_addr <= row_next;
          col_addr <= row_next;
        end else begin
          col_i    <= col_i + R_W'(1);
          col_addr <= col_next;
        end
      end

      if (rd_pend) begin
        sums[0] <= sums[0] + SUM_W'(rd_data[7:0]);
        sums[1] <= sums[1] + SUM_W'(rd_data[15:8]);
        sums[2] <= sums[2] + SUM_W'(rd_data[23:16]);
      end

      // restoring divide, one quotient bit per cycle on all three channels
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= DC_W'(SUM_W);
        rem      <= '0;
        quo      <= sums;
      end else if (div_busy) begin
        for (int c = 0; c < 3; c++) begin
          if ({rem[c][CNT_W-1:0], quo[c][SUM_W-1]} >= (CNT_W + 1)'(cnt)) begin
            rem[c] <= {rem[c][CNT_W-1:0], quo[c][SUM_W-1]} - (CNT_W + 1)'(cnt);
            quo[c] <= {quo[c][SUM_W-2:0], 1'b1};
          end else begin
            rem[c] <= {rem[c][CNT_W-1:0], quo[c][SUM_W-1]};
            quo[c] <= {quo[c][SUM_W-2:0], 1'b0};
          end
        end
        div_cnt <= div_cnt - DC_W'(1);
        if (div_cnt == DC_W'(1)) div_busy <= 1'b0;
      end

      if (cmd.load) begin
        out_valid           <= 1'b1;
        out_data.out_red    <= quo[0][7:0];
        out_data.out_green  <= quo[1][7:0];
        out_data.out_blue   <= quo[2][7:0];
        out_data.frame_done <= (out_pos + TOT_W'(1)) >= total;
        if ((out_pos + TOT_W'(1)) >= total) active <= 1'b0;
        out_pos <= out_pos + TOT_W'(1);
        addr_p  <= (32'(addr_p) == 32'(DEPTH - 1)) ? '0 : addr_p + A_W'(1);
        if (px == frame_w - W_W'(1)) begin
          px <= '0;
          py <= py + H_W'(1);
        end else begin
          px <= px + W_W'(1);
        end
      end
    end
  end

  always_comb begin
    sts.active   = active;
    sts.tick     = item.req_type;
    sts.emit     = in_pos > lag;
    sts.sum_done = !sum_active && !rd_pend;
    sts.div_done = !div_busy;
    sts.out_full = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

// File: src/box_blur_rgb_clipped.sv
// Top level of the clipped RGB box blur: controller plus datapath.
//
// Streaming (2*RADIUS+1)-square box blur of RGB pixels in raster order. Each
// result is the floor mean of every channel over the window clipped to the
// image; the result for pixel p leaves after input beat p + RADIUS*width +
// RADIUS, so the host sends that many drain beats after the frame. Geometry
// is sampled when the first pixel of a frame arrives. An input beat that
// yields a result reads the in-image window pixels, one per cycle from the
// single-port line store (up to (2*RADIUS+1)^2 of them), and then divides
// the three channel sums by their count in a bit-serial divide that works
// on all three channels at once. The line store needs no clearing after
// reset. A finished result waits in the output register while the next beat
// is taken.
`default_nettype none
module box_blur_rgb_clipped
  import bbr_pkg::*;
#(
  parameter int RADIUS     = DEF_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  cmd_t cmd;
  sts_t sts;

  bbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbr_datapath #(
    .RADIUS     (RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
